/* sv/asg_pkg.sv */
// Package for the aliquot sequence generator: widths, limits, codes and
// the request and response structs of the shared arithmetic unit.
// No dependencies.
package asg_pkg;

   localparam int VAL_W   = 53;   // width of a sequence term
   localparam int IDX_W   = 6;    // width of a term index
   localparam int LEN_W   = 7;    // width of a sequence length
   localparam int ACC_W   = 64;   // width of the divisor-sum datapath
   localparam int P_W     = 32;   // width of a trial divisor
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 6;

   localparam int MAX_TERMS = 64;
   localparam logic [VAL_W-1:0] TERM_LIMIT = 53'd1000000000000000;
   localparam logic [IDX_W-1:0] LIM_MAX = IDX_W'(MAX_TERMS - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_MODE  = 1'b1;

   typedef enum logic [1:0] {
      STOP_RUN   = 2'd0,
      STOP_ZERO  = 2'd1,
      STOP_LIMIT = 2'd2,
      STOP_BIG   = 2'd3
   } stop_type;

   typedef enum logic {
      OP_DIV = 1'b0,
      OP_MUL = 1'b1
   } alu_op_type;

   // For OP_DIV, a holds the dividend and b the divisor.
   // For OP_MUL, a holds the multiplier and b the multiplicand.
   typedef struct packed {
      logic             go;
      alu_op_type       op;
      logic [ACC_W-1:0] a;
      logic [ACC_W-1:0] b;
   } alu_req_type;

   // After a division, x holds the quotient and acc the remainder.
   // After a multiplication, acc holds the product.
   typedef struct packed {
      logic             done;
      logic [ACC_W-1:0] x;
      logic [ACC_W-1:0] acc;
   } alu_rsp_type;

endpackage

/* sv/asg_ifs.sv */
// Handshake interfaces of the aliquot sequence generator: start numbers,
// sequence terms and register writes. Depends on asg_pkg.
interface asg_req_if;
   import asg_pkg::*;
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] start_number;
   modport source (output valid, output start_number, input ready);
   modport sink   (input valid, input start_number, output ready);
endinterface

interface asg_rsp_if;
   import asg_pkg::*;
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] term_value;
   logic [IDX_W-1:0] term_index;
   logic [LEN_W-1:0] seq_length;
   logic [1:0]       stop_reason;
   logic             last_result;
   modport source (output valid, output term_value, output term_index,
                   output seq_length, output stop_reason, output last_result,
                   input ready);
   modport sink   (input valid, input term_value, input term_index,
                   input seq_length, input stop_reason, input last_result,
                   output ready);
endinterface

interface asg_csr_if;
   import asg_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/asg_alu.sv */
// Shared multi-cycle arithmetic unit: restoring division one quotient bit
// per cycle, and shift-add multiplication one multiplier bit per cycle.
// Both use the same adder. Depends on asg_pkg.
module asg_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  asg_pkg::alu_req_type alu_req,
   output asg_pkg::alu_rsp_type alu_rsp
);
   import asg_pkg::*;

   localparam int CNT_W = $clog2(VAL_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   alu_op_type       op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0] x_ff, x_in;
   logic [ACC_W-1:0] y_ff, y_in;
   logic [ACC_W-1:0] acc_ff, acc_in;

   logic [P_W:0]     shifted;
   logic [ACC_W-1:0] opa, opb;
   logic             sub;
   logic [ACC_W:0]   sum;
   logic             ge;

   // The partial remainder stays below the divisor, so it fits in P_W bits.
   assign shifted = {acc_ff[P_W-1:0], x_ff[VAL_W-1]};
   assign sub     = (op_ff == OP_DIV);
   assign opa     = sub ? {{(ACC_W-P_W-1){1'b0}}, shifted} : acc_ff;
   assign opb     = sub ? ~y_ff : y_ff;
   assign sum     = {1'b0, opa} + {1'b0, opb} + {{ACC_W{1'b0}}, sub};
   assign ge      = sum[ACC_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      if (alu_req.go) begin
         busy_in = 1'b1;
         op_in   = alu_req.op;
         cnt_in  = '0;
         x_in    = alu_req.a;
         y_in    = alu_req.b;
         acc_in  = '0;
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_DIV: begin
               x_in   = {x_ff[ACC_W-2:0], ge};
               acc_in = {{(ACC_W-P_W){1'b0}}, ge ? sum[P_W-1:0] : shifted[P_W-1:0]};
               cnt_in = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(VAL_W - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            OP_MUL: begin
               if (x_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  if (x_ff[0]) acc_in = sum[ACC_W-1:0];
                  x_in = {1'b0, x_ff[ACC_W-1:1]};
                  y_in = {y_ff[ACC_W-2:0], 1'b0};
               end
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_DIV;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign alu_rsp.done = done_ff;
   assign alu_rsp.x    = x_ff;
   assign alu_rsp.acc  = acc_ff;

endmodule

/* sv/aliquot_sequence_generator.sv */
// Aliquot sequence generator, top level: sequencer, registers, output word.
// Depends on asg_pkg, asg_ifs and asg_alu.
//
// A start number is taken on req when the block is idle. The block then
// walks the aliquot sequence, each next term being the sum of the proper
// divisors of the current one, found by trial division from the prime
// factorization. In full mode every term goes out on rsp as one word; in
// length mode a single word carries the length and stop reason. The last
// word has last_result set and the stop reason: zero reached, index limit
// (max_length, 0 meaning 63) reached, or a term above 10^15.
// The divider sets the pace. Each trial divisor costs one division, each
// prime power found a multiplication and a division more and each prime
// a multiplication more; trial divisors run up to the square root of the
// remaining cofactor, so the largest terms take longest.
// req.ready is high only between start numbers.
// csr writes (index 0 max_length, index 1 full_mode) are always taken and
// apply from the next start number on.
// Reset empties the output register, drops to idle and sets max_length to
// 63 and full_mode to 1. When rsp stalls, the word waits in the output
// register and the sequencer holds before placing the next one.
module aliquot_sequence_generator (
   input logic         clock,
   input logic         reset,
   asg_req_if.sink     req,
   asg_rsp_if.source   rsp,
   asg_csr_if.sink     csr
);
   import asg_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_CHECK = 13'b0000000000010,
      S_ODIV  = 13'b0000000000100,
      S_OWAIT = 13'b0000000001000,
      S_PMUL  = 13'b0000000010000,
      S_PWAIT = 13'b0000000100000,
      S_IDIV  = 13'b0000001000000,
      S_IWAIT = 13'b0000010000000,
      S_SMUL  = 13'b0000100000000,
      S_SWAIT = 13'b0001000000000,
      S_FIN   = 13'b0010000000000,
      S_FWAIT = 13'b0100000000000,
      S_NEXT  = 13'b1000000000000
   } state_type;

   state_type        state_ff, state_in;

   logic [IDX_W-1:0] max_length_ff, max_length_in;
   logic             full_mode_ff, full_mode_in;

   logic [VAL_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] lim_ff, lim_in;
   logic             full_ff, full_in;
   logic [VAL_W-1:0] m_ff, m_in;
   logic [P_W-1:0]   p_ff, p_in;
   logic [ACC_W-1:0] sigma_ff, sigma_in;
   logic [ACC_W-1:0] part_ff, part_in;
   logic [ACC_W-1:0] pw_ff, pw_in;

   logic             out_valid_ff, out_valid_in;
   logic [VAL_W-1:0] out_value_ff, out_value_in;
   logic [IDX_W-1:0] out_index_ff, out_index_in;
   logic [LEN_W-1:0] out_length_ff, out_length_in;
   stop_type         out_reason_ff, out_reason_in;
   logic             out_last_ff, out_last_in;

   alu_req_type      alu_req;
   alu_rsp_type      alu_rsp;

   stop_type         reason;
   logic [LEN_W-1:0] length;
   logic             out_free;
   logic [VAL_W-1:0] quot;
   logic [P_W-1:0]   rem;
   logic [P_W-1:0]   p_next;

   asg_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign quot   = alu_rsp.x[VAL_W-1:0];
   assign rem    = alu_rsp.acc[P_W-1:0];
   assign p_next = (p_ff == P_W'(2)) ? P_W'(3) : p_ff + P_W'(2);
   assign out_free = !out_valid_ff || rsp.ready;

   // Zero is checked before the term limit, and both before the index limit.
   always_comb begin
      if (n_ff == '0) begin
         reason = STOP_ZERO;
         length = {1'b0, k_ff};
      end else if (n_ff > TERM_LIMIT) begin
         reason = STOP_BIG;
         length = {1'b0, k_ff};
      end else if (k_ff >= lim_ff) begin
         reason = STOP_LIMIT;
         length = {1'b0, lim_ff} + LEN_W'(1);
      end else begin
         reason = STOP_RUN;
         length = '0;
      end
   end

   always_comb begin
      max_length_in = max_length_ff;
      full_mode_in  = full_mode_ff;
      if (csr.valid) begin
         if (csr.index == CSR_MAX_LENGTH) max_length_in = csr.data[IDX_W-1:0];
         else full_mode_in = csr.data[0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      lim_in        = lim_ff;
      full_in       = full_ff;
      m_in          = m_ff;
      p_in          = p_ff;
      sigma_in      = sigma_ff;
      part_in       = part_ff;
      pw_in         = pw_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_value_in  = out_value_ff;
      out_index_in  = out_index_ff;
      out_length_in = out_length_ff;
      out_reason_in = out_reason_ff;
      out_last_in   = out_last_ff;
      alu_req.go    = 1'b0;
      alu_req.op    = OP_DIV;
      alu_req.a     = {{(ACC_W-VAL_W){1'b0}}, m_ff};
      alu_req.b     = {{(ACC_W-P_W){1'b0}}, p_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               n_in     = req.start_number;
               k_in     = '0;
               lim_in   = (max_length_ff == '0 || max_length_ff > LIM_MAX) ?
                          LIM_MAX : max_length_ff;
               full_in  = full_mode_ff;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (full_ff || reason != STOP_RUN) begin
               if (out_free) begin
                  out_valid_in  = 1'b1;
                  out_value_in  = full_ff ? n_ff : '0;
                  out_index_in  = k_ff;
                  out_length_in = length;
                  out_reason_in = reason;
                  out_last_in   = (reason != STOP_RUN);
                  if (reason != STOP_RUN) begin
                     state_in = S_IDLE;
                  end else begin
                     m_in     = n_ff;
                     p_in     = P_W'(2);
                     sigma_in = ACC_W'(1);
                     state_in = S_ODIV;
                  end
               end
            end else begin
               m_in     = n_ff;
               p_in     = P_W'(2);
               sigma_in = ACC_W'(1);
               state_in = S_ODIV;
            end
         end
         S_ODIV: begin
            alu_req.go = 1'b1;
            state_in   = S_OWAIT;
         end
         S_OWAIT: begin
            if (alu_rsp.done) begin
               // Trial division stops once p exceeds m / p.
               if ({{(VAL_W-P_W){1'b0}}, p_ff} > quot) begin
                  state_in = S_FIN;
               end else if (rem != '0) begin
                  p_in     = p_next;
                  state_in = S_ODIV;
               end else begin
                  m_in     = quot;
                  part_in  = ACC_W'(1);
                  pw_in    = ACC_W'(1);
                  state_in = S_PMUL;
               end
            end
         end
         S_PMUL: begin
            alu_req.go = 1'b1;
            alu_req.op = OP_MUL;
            alu_req.a  = {{(ACC_W-P_W){1'b0}}, p_ff};
            alu_req.b  = pw_ff;
            state_in   = S_PWAIT;
         end
         S_PWAIT: begin
            if (alu_rsp.done) begin
               pw_in    = alu_rsp.acc;
               part_in  = part_ff + alu_rsp.acc;
               state_in = S_IDIV;
            end
         end
         S_IDIV: begin
            alu_req.go = 1'b1;
            state_in   = S_IWAIT;
         end
         S_IWAIT: begin
            if (alu_rsp.done) begin
               if (rem == '0) begin
                  m_in     = quot;
                  state_in = S_PMUL;
               end else begin
                  state_in = S_SMUL;
               end
            end
         end
         S_SMUL: begin
            alu_req.go = 1'b1;
            alu_req.op = OP_MUL;
            alu_req.a  = part_ff;
            alu_req.b  = sigma_ff;
            state_in   = S_SWAIT;
         end
         S_SWAIT: begin
            if (alu_rsp.done) begin
               sigma_in = alu_rsp.acc;
               p_in     = p_next;
               state_in = S_ODIV;
            end
         end
         S_FIN: begin
            // A cofactor left above one is a prime of its own.
            if (m_ff > VAL_W'(1)) begin
               alu_req.go = 1'b1;
               alu_req.op = OP_MUL;
               alu_req.a  = {{(ACC_W-VAL_W){1'b0}}, m_ff} + ACC_W'(1);
               alu_req.b  = sigma_ff;
               state_in   = S_FWAIT;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_FWAIT: begin
            if (alu_rsp.done) begin
               sigma_in = alu_rsp.acc;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            n_in     = sigma_ff[VAL_W-1:0] - n_ff;
            k_in     = k_ff + IDX_W'(1);
            state_in = S_CHECK;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         max_length_ff <= IDX_W'(63);
         full_mode_ff  <= 1'b1;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_length_ff <= max_length_in;
         full_mode_ff  <= full_mode_in;
         out_valid_ff  <= out_valid_in;
      end
      n_ff          <= n_in;
      k_ff          <= k_in;
      lim_ff        <= lim_in;
      full_ff       <= full_in;
      m_ff          <= m_in;
      p_ff          <= p_in;
      sigma_ff      <= sigma_in;
      part_ff       <= part_in;
      pw_ff         <= pw_in;
      out_value_ff  <= out_value_in;
      out_index_ff  <= out_index_in;
      out_length_ff <= out_length_in;
      out_reason_ff <= out_reason_in;
      out_last_ff   <= out_last_in;
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign csr.ready       = 1'b1;
   assign rsp.valid       = out_valid_ff;
   assign rsp.term_value  = out_value_ff;
   assign rsp.term_index  = out_index_ff;
   assign rsp.seq_length  = out_length_ff;
   assign rsp.stop_reason = out_reason_ff;
   assign rsp.last_result = out_last_ff;

   // The arithmetic unit finishes only while the sequencer waits for it.
   a_alu_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> (state_ff == S_OWAIT || state_ff == S_PWAIT ||
                        state_ff == S_IWAIT || state_ff == S_SWAIT ||
                        state_ff == S_FWAIT))
      else $error("arithmetic unit finished outside a wait state");

   // The final word of a sequence always carries a stop reason, the others none.
   a_last_has_reason: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_last_ff == (out_reason_ff != STOP_RUN)))
      else $error("last_result and stop_reason disagree");

   // Trial division starts only on a nonzero cofactor with a divisor of two or more.
   a_div_operands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ODIV) |-> (m_ff != '0 && p_ff >= P_W'(2)))
      else $error("division issued with bad operands");

   // A new term is formed only below the index limit.
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NEXT) |-> (k_ff < lim_ff))
      else $error("term index ran past its limit");

endmodule
